@@ hdl/qbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Quote and bracket balance checker package
// Shared constants, types and character codes for the checker.
// ----------------------------------------------------------------------------
package qbc_pkg;

    // Number of open marks the stack holds.
    localparam int STACK_DEPTH = 64;
    // Stack depth counter holds 0 .. STACK_DEPTH.
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    // Address of one stack entry.
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef logic [DEPTH_W-1:0] t_depth;
    typedef logic [ADDR_W-1:0]  t_addr;

    typedef enum logic [1:0] {
        MARK_NONE  = 2'd0,
        MARK_PAREN = 2'd1,
        MARK_SQ    = 2'd2,
        MARK_DQ    = 2'd3
    } t_mark;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FORMAT   = 2'd1,
        ST_RESTRICT = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

endpackage

@@ hdl/qbc_if.sv @@
// ----------------------------------------------------------------------------
// Quote and bracket balance checker channels
// Valid/ready channels for command bytes and verdicts.
// ----------------------------------------------------------------------------
interface qbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface qbc_out_if;
    logic              valid;
    logic              ready;
    qbc_pkg::t_status  status;
    logic              command_done;

    modport source (output valid, output status, output command_done, input ready);
    modport sink   (input valid, input status, input command_done, output ready);
endinterface

@@ hdl/quote_bracket_balance_checker.sv @@
// ----------------------------------------------------------------------------
// Quote and bracket balance checker
// Checks shell-style nesting of parens and quotes, one command byte per beat.
// ----------------------------------------------------------------------------
// Usage: command bytes enter on i_in (byte_value, last_byte) and one verdict
// beat leaves on o_out (status, command_done) for every input beat. The
// status is the sticky verdict after that byte; command_done repeats
// last_byte and marks the final verdict of the command.
// Each verdict is registered onto o_out at the edge that accepts its byte.
// Throughput is one byte per cycle while the receiver keeps up. The top
// mark sits in a register and the mark beneath it is read ahead from the
// stack RAM every cycle, so pushes and pops run back to back.
// Reset (synchronous, active low) empties the stack, clears the error and
// drops the output beat; the stack RAM itself needs no clearing because only
// entries below the current depth are ever used.
// When the receiver stalls, the verdict holds in the output register and
// i_in.ready stays low until it is taken; a new byte is accepted in the same
// cycle the held verdict leaves.
// ----------------------------------------------------------------------------
module quote_bracket_balance_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qbc_in_if.sink    i_in,
    qbc_out_if.source o_out
);
    import qbc_pkg::*;

    logic    fire;
    t_status core_status;

    logic    r_out_valid;
    t_status r_status;
    logic    r_done;

    // The output register may be refilled in the cycle its beat is taken.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign fire       = i_in.valid && i_in.ready;

    qbc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (i_in.byte_value),
        .i_last   (i_in.last_byte),
        .o_status (core_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= core_status;
            r_done   <= i_in.last_byte;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.command_done = r_done;

endmodule

@@ hdl/qbc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered (read-old).
// ----------------------------------------------------------------------------
module qbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hdl/qbc_core.sv @@
// ----------------------------------------------------------------------------
// Quote and bracket stack engine
// Keeps the top mark in a register and the marks below it in a RAM. The
// entry under the top is read ahead every cycle so that a pop finds it
// ready without waiting on the RAM; a write to that same entry is forwarded.
// ----------------------------------------------------------------------------
module qbc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output qbc_pkg::t_status o_status
);
    import qbc_pkg::*;

    t_depth  r_depth, n_depth;
    t_mark   r_top, n_top;
    t_status r_err, n_err;
    logic    r_dollar, n_dollar;

    logic    r_fwd;
    t_mark   r_fwd_data;

    logic    ram_we;
    t_addr   ram_waddr;
    t_mark   ram_wdata;
    t_addr   ram_raddr;
    logic [1:0] ram_rdata;

    t_mark   below;
    t_mark   top;
    logic    empty;
    t_depth  depth_m1;
    t_depth  next_m2;

    assign empty    = (r_depth == '0);
    assign top      = empty ? MARK_NONE : r_top;
    assign below    = r_fwd ? r_fwd_data : t_mark'(ram_rdata);
    assign depth_m1 = r_depth - t_depth'(1);
    assign next_m2  = n_depth - t_depth'(2);

    // Always look at the entry that will sit under the next top.
    assign ram_raddr = next_m2[ADDR_W-1:0];

    always_comb begin
        logic    do_push;
        logic    do_pop;
        t_mark   push_mark;
        t_status v_err;

        do_push   = 1'b0;
        do_pop    = 1'b0;
        push_mark = MARK_PAREN;
        n_depth   = r_depth;
        n_top     = r_top;
        n_err     = r_err;
        n_dollar  = r_dollar;
        ram_we    = 1'b0;
        ram_waddr = depth_m1[ADDR_W-1:0];
        ram_wdata = r_top;

        if (i_fire && (r_err == ST_OK)) begin
            case (i_byte)
                CH_LPAREN: begin
                    if (top != MARK_SQ && (r_dollar || empty || top == MARK_PAREN)) begin
                        do_push   = 1'b1;
                        push_mark = MARK_PAREN;
                    end
                end
                CH_RPAREN: begin
                    if (top == MARK_PAREN) begin
                        do_pop = 1'b1;
                    end else if (empty) begin
                        n_err = ST_FORMAT;
                    end
                end
                CH_SQUOTE: begin
                    if (top == MARK_SQ) begin
                        do_pop = 1'b1;
                    end else if (top != MARK_DQ) begin
                        do_push   = 1'b1;
                        push_mark = MARK_SQ;
                    end
                end
                CH_DQUOTE: begin
                    if (top == MARK_DQ) begin
                        do_pop = 1'b1;
                    end else if (top != MARK_SQ) begin
                        do_push   = 1'b1;
                        push_mark = MARK_DQ;
                    end
                end
                CH_BSLASH: begin
                    n_err = ST_RESTRICT;
                end
                default: begin
                end
            endcase
            n_dollar = (i_byte == CH_DOLLAR);
        end

        if (do_push) begin
            if (r_depth == t_depth'(STACK_DEPTH)) begin
                n_err = ST_OVERFLOW;
            end else begin
                // The old top moves down into the RAM.
                ram_we  = !empty;
                n_top   = push_mark;
                n_depth = r_depth + t_depth'(1);
            end
        end else if (do_pop) begin
            n_top   = below;
            n_depth = depth_m1;
        end

        if (i_fire && i_last && n_err == ST_OK && n_depth != '0) begin
            n_err = ST_FORMAT;
        end
        v_err    = n_err;
        o_status = v_err;

        if (i_fire && i_last) begin
            n_depth  = '0;
            n_err    = ST_OK;
            n_dollar = 1'b0;
        end
    end

    qbc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= '0;
            r_err    <= ST_OK;
            r_dollar <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            r_depth  <= n_depth;
            r_err    <= n_err;
            r_dollar <= n_dollar;
            r_fwd    <= ram_we && (ram_waddr == ram_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_fwd_data <= ram_wdata;
    end

endmodule

@@ bench/tb_quote_bracket_balance_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quote and bracket balance checker testbench
// Drives command bytes through the valid/ready input channel, predicts each
// verdict with an independent copy of the nesting rules and compares every
// verdict beat against it, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_quote_bracket_balance_checker;

    import qbc_pkg::*;

    // Random stimulus stops once this many bytes have gone in.
    localparam int RANDOM_ITEMS = 1420;
    // The run is called hung well past the slowest legal run.
    localparam int CYCLE_LIMIT  = 1000000;
    // Length of the deliberate receiver hold-off, in clock cycles.
    localparam int LONG_HOLD    = 150;

    typedef logic [7:0] t_char;

    // One verdict beat as the output channel carries it.
    typedef struct packed {
        t_status status;
        logic    command_done;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    qbc_in_if  in_ch();
    qbc_out_if out_ch();

    quote_bracket_balance_checker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Verdicts still owed by the block, oldest first.
    t_verdict expected_verdicts[$];
    int       mismatches  = 0;
    int       cycle_count = 0;

    // Idling controls, flipped by the test tasks.
    bit src_idle_on   = 1'b0;
    bit sink_stall_on = 1'b0;
    bit hold_off_req  = 1'b0;

    // Bytes of the command being built.
    t_char cmd_buf[$];

    // Shadow of the checker state: open marks, their count, the sticky
    // error and whether the previous byte of this command was a dollar.
    t_mark   open_mark[STACK_DEPTH];
    int      mark_count   = 0;
    t_status sticky_err   = ST_OK;
    bit      after_dollar = 1'b0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Verdict prediction
    // ------------------------------------------------------------------------

    // A push onto a full stack leaves the stack alone and flags overflow.
    function automatic void push_open_mark(t_mark m);
        if (mark_count >= STACK_DEPTH) begin
            sticky_err = ST_OVERFLOW;
        end else begin
            open_mark[mark_count] = m;
            mark_count++;
        end
    endfunction

    // Applies one command byte to the shadow state and returns the verdict
    // beat that the block must produce for it.
    function automatic t_verdict next_verdict(t_char value, logic is_last);
        t_verdict v;
        t_mark    top;
        bit       empty;
        top   = (mark_count == 0) ? MARK_NONE : open_mark[mark_count - 1];
        empty = (mark_count == 0);
        // Once an error is set, the rest of the command is ignored.
        if (sticky_err == ST_OK) begin
            case (value)
                CH_LPAREN: begin
                    // Inside double quotes only a dollar-paren opens a group.
                    if (top != MARK_SQ && (after_dollar || empty || top == MARK_PAREN))
                        push_open_mark(MARK_PAREN);
                end
                CH_RPAREN: begin
                    // A close paren with a quote on top is plain text.
                    if (top == MARK_PAREN)
                        mark_count--;
                    else if (empty)
                        sticky_err = ST_FORMAT;
                end
                CH_SQUOTE: begin
                    if (top == MARK_SQ)
                        mark_count--;
                    else if (top != MARK_DQ)
                        push_open_mark(MARK_SQ);
                end
                CH_DQUOTE: begin
                    if (top == MARK_DQ)
                        mark_count--;
                    else if (top != MARK_SQ)
                        push_open_mark(MARK_DQ);
                end
                CH_BSLASH: begin
                    // Backslash is restricted even inside quotes.
                    sticky_err = ST_RESTRICT;
                end
                default: ;
            endcase
            after_dollar = (value == CH_DOLLAR);
        end
        // Anything still open at the end of the command is a format error.
        if (is_last && sticky_err == ST_OK && mark_count != 0)
            sticky_err = ST_FORMAT;
        v.status       = sticky_err;
        v.command_done = is_last;
        if (is_last) begin
            mark_count   = 0;
            sticky_err   = ST_OK;
            after_dollar = 1'b0;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_char special_byte();
        case ($urandom_range(0, 5))
            0:       return CH_LPAREN;
            1:       return CH_RPAREN;
            2:       return CH_SQUOTE;
            3:       return CH_DQUOTE;
            4:       return CH_BSLASH;
            default: return CH_DOLLAR;
        endcase
    endfunction

    // A byte that leaves the nesting unchanged under the given top mark.
    // Inside single quotes almost anything goes; inside double quotes the
    // ignored parens and single quotes are allowed too.
    function automatic t_char text_byte(t_mark top);
        t_char v;
        bit    ok;
        do begin
            v = t_char'($urandom_range(0, 255));
            case (top)
                MARK_SQ: ok = (v != CH_SQUOTE) && (v != CH_BSLASH);
                MARK_DQ: ok = (v != CH_DQUOTE) && (v != CH_BSLASH) && (v != CH_DOLLAR);
                default: ok = (v != CH_LPAREN) && (v != CH_RPAREN) && (v != CH_SQUOTE) &&
                              (v != CH_DQUOTE) && (v != CH_BSLASH) && (v != CH_DOLLAR);
            endcase
        end while (!ok);
        return v;
    endfunction

    function automatic void close_mark(t_mark m);
        case (m)
            MARK_PAREN: cmd_buf.push_back(CH_RPAREN);
            MARK_SQ:    cmd_buf.push_back(CH_SQUOTE);
            default:    cmd_buf.push_back(CH_DQUOTE);
        endcase
    endfunction

    // Builds a properly nested command: a random walk of opens, closes and
    // text that closes whatever is still open at the end. The open share
    // sets how deep it tends to go; max_open past the stack size overflows.
    function automatic void build_wellformed(int max_open, int steps, int open_pct);
        t_mark plan[$];
        t_mark top;
        int    act;
        int    r;
        cmd_buf.delete();
        for (int i = 0; i < steps; i++) begin
            top = (plan.size() == 0) ? MARK_NONE : plan[plan.size() - 1];
            act = $urandom_range(0, 99);
            if (act < open_pct && plan.size() < max_open && top != MARK_SQ) begin
                if (top == MARK_DQ) begin
                    cmd_buf.push_back(CH_DOLLAR);
                    cmd_buf.push_back(CH_LPAREN);
                    plan.push_back(MARK_PAREN);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 60) begin
                        cmd_buf.push_back(CH_LPAREN);
                        plan.push_back(MARK_PAREN);
                    end else if (r < 80) begin
                        cmd_buf.push_back(CH_SQUOTE);
                        plan.push_back(MARK_SQ);
                    end else begin
                        cmd_buf.push_back(CH_DQUOTE);
                        plan.push_back(MARK_DQ);
                    end
                end
            end else if (act >= open_pct + (100 - open_pct) / 2 && plan.size() > 0) begin
                close_mark(plan.pop_back());
            end else begin
                cmd_buf.push_back(text_byte(top));
            end
        end
        while (plan.size() > 0)
            close_mark(plan.pop_back());
    endfunction

    // Damages a well-formed command in one of a few typical ways.
    function automatic void break_command();
        int pos;
        pos = $urandom_range(0, cmd_buf.size() - 1);
        case ($urandom_range(0, 3))
            0: cmd_buf[pos] = special_byte();
            1: cmd_buf.insert(pos, CH_BSLASH);
            2: begin
                if (cmd_buf.size() > 1)
                    void'(cmd_buf.pop_back());
                else
                    cmd_buf[0] = CH_RPAREN;
            end
            default: cmd_buf.push_front(CH_RPAREN);
        endcase
    endfunction

    // Random bytes, half of them drawn from the special characters.
    function automatic void build_noise(int len);
        cmd_buf.delete();
        repeat (len) begin
            if ($urandom_range(0, 1))
                cmd_buf.push_back(special_byte());
            else
                cmd_buf.push_back(t_char'($urandom_range(0, 255)));
        end
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Offers one byte, optionally after a random gap, and waits until the
    // block takes it. The verdict is predicted at the accepting edge.
    task automatic send_byte(input t_char value, input logic is_last);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid      <= 1'b0;
            in_ch.byte_value <= t_char'($urandom_range(0, 255));
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.byte_value <= value;
        in_ch.last_byte  <= is_last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_verdicts.push_back(next_verdict(value, is_last));
    endtask

    // Sends the built command, marking its final byte as the last one.
    task automatic send_command();
        for (int i = 0; i < cmd_buf.size(); i++)
            send_byte(cmd_buf[i], i == cmd_buf.size() - 1);
    endtask

    // Receiver: random stalls when enabled, plus one long hold-off on
    // request, counted here so the sender keeps offering bytes meanwhile.
    initial begin : verdict_drain
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (sink_stall_on)
                    stall_left = pick_gap();
            end
        end
    end

    // Every verdict beat taken is matched against the oldest prediction.
    always @(posedge i_clk) begin : verdict_check
        t_verdict want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_verdicts.size() == 0) begin
                $error("verdict beat with none expected: status %0d, command_done %0d",
                       out_ch.status, out_ch.command_done);
                mismatches++;
            end else begin
                want = expected_verdicts.pop_front();
                if (out_ch.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, out_ch.status);
                    mismatches++;
                end
                if (out_ch.command_done !== want.command_done) begin
                    $error("command_done: expected %0d, actual %0d",
                           want.command_done, out_ch.command_done);
                    mismatches++;
                end
            end
        end
    end

    // A hung block ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("quote_bracket_balance_checker regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Byte extremes, every special character and each corner of the rules,
    // sent back to back with no idling.
    task automatic test_directed_cases();
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
        // Plain bytes at both ends of the range.
        cmd_buf = {8'h00, 8'hFF};
        send_command();
        // Nested parens that balance.
        cmd_buf = {CH_LPAREN, CH_LPAREN, CH_RPAREN, CH_RPAREN};
        send_command();
        // Close paren on an empty stack.
        cmd_buf = {CH_RPAREN};
        send_command();
        // Paren still open at the last byte.
        cmd_buf = {CH_LPAREN};
        send_command();
        // Close paren under a single quote is text.
        cmd_buf = {CH_SQUOTE, CH_RPAREN, CH_SQUOTE};
        send_command();
        // Open paren in double quotes without a dollar is text.
        cmd_buf = {CH_DQUOTE, CH_LPAREN, CH_DQUOTE};
        send_command();
        // Dollar-paren inside double quotes opens a group.
        cmd_buf = {CH_DQUOTE, CH_DOLLAR, CH_LPAREN, CH_RPAREN, CH_DQUOTE};
        send_command();
        // Backslash inside quotes; the error then sticks over the open paren
        // and the unclosed quote.
        cmd_buf = {CH_SQUOTE, CH_BSLASH, CH_LPAREN};
        send_command();
        // Close paren with a double quote on top is ignored; the quote then
        // stays open at the end.
        cmd_buf = {CH_DQUOTE, CH_RPAREN};
        send_command();
    endtask

    // Filling the mark stack exactly, and one push past it.
    task automatic test_stack_limit();
        src_idle_on   = 1'b1;
        sink_stall_on = 1'b1;
        // One paren too many; the close that follows is ignored.
        cmd_buf.delete();
        repeat (STACK_DEPTH + 1) cmd_buf.push_back(CH_LPAREN);
        cmd_buf.push_back(CH_RPAREN);
        send_command();
        // Full stack with a double quote on top, then a dollar-paren.
        cmd_buf.delete();
        repeat (STACK_DEPTH - 1) cmd_buf.push_back(CH_LPAREN);
        cmd_buf.push_back(CH_DQUOTE);
        cmd_buf.push_back(CH_DOLLAR);
        cmd_buf.push_back(CH_LPAREN);
        cmd_buf.push_back(CH_DQUOTE);
        send_command();
        // Exactly full, then drained to empty: no error.
        cmd_buf.delete();
        repeat (STACK_DEPTH) cmd_buf.push_back(CH_LPAREN);
        repeat (STACK_DEPTH) cmd_buf.push_back(CH_RPAREN);
        send_command();
    endtask

    // The receiver holds off for a long stretch while bytes keep coming, so
    // the output register fills and the input has to stall.
    task automatic test_backpressure();
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
        hold_off_req  = 1'b1;
        build_wellformed(4, 30, 30);
        send_command();
    endtask

    // Mostly well-formed commands with random content, some damaged ones,
    // some noise and a few deep ones that run into the stack limit. The
    // idling mode changes every few commands, so some stretches run flat out.
    task automatic test_random_commands();
        int sent;
        int cmd_no;
        int flavor;
        sent   = 0;
        cmd_no = 0;
        while (sent < RANDOM_ITEMS) begin
            if (cmd_no % 16 == 0) begin
                src_idle_on   = 1'($urandom_range(0, 1));
                sink_stall_on = 1'($urandom_range(0, 1));
            end
            flavor = $urandom_range(0, 99);
            if (flavor < 3) begin
                build_wellformed(STACK_DEPTH + 6, 140, 90);
            end else if (flavor < 70) begin
                build_wellformed($urandom_range(1, 6), $urandom_range(1, 14), 30);
            end else if (flavor < 90) begin
                build_wellformed($urandom_range(1, 6), $urandom_range(2, 14), 30);
                break_command();
            end else begin
                build_noise($urandom_range(1, 10));
            end
            send_command();
            sent += cmd_buf.size();
            cmd_no++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin : main
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.byte_value = 8'h00;
        in_ch.last_byte  = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_stack_limit();
        test_backpressure();
        test_random_commands();

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        // Let the remaining verdicts drain, then a few more cycles to catch
        // any stray beat.
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("quote_bracket_balance_checker regression: pass");
        end else begin
            $display("quote_bracket_balance_checker regression: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/qbc_pkg.sv
hdl/qbc_if.sv
hdl/qbc_ram.sv
hdl/qbc_core.sv
hdl/quote_bracket_balance_checker.sv
bench/tb_quote_bracket_balance_checker.sv
